// File: rtl/rau_pkg.sv
package rau_pkg;

  // datapath width; products and quotients wrap at this many bits
  localparam int WIDTH = 32;
  localparam int CNT_W = $clog2(WIDTH);

  localparam logic [2:0] OP_ADD = 3'd0;
  localparam logic [2:0] OP_SUB = 3'd1;
  localparam logic [2:0] OP_MUL = 3'd2;
  localparam logic [2:0] OP_DIV = 3'd3;
  localparam logic [2:0] OP_RED = 3'd4;

  typedef struct packed {
    logic        [2:0]       op;
    logic signed [WIDTH-1:0] a_num;
    logic signed [WIDTH-1:0] a_den;
    logic signed [WIDTH-1:0] b_num;
    logic signed [WIDTH-1:0] b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [WIDTH-1:0] res_num;
    logic signed [WIDTH-1:0] res_den;
  } rau_out_t;

  // magnitude divider request / response
  typedef struct packed {
    logic             start;
    logic [WIDTH-1:0] dividend;
    logic [WIDTH-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [WIDTH-1:0] quotient;
    logic [WIDTH-1:0] remainder;
  } div_rsp_t;

endpackage

// File: rtl/rau_div.sv
// Unsigned restoring divider, one quotient bit per cycle.
module rau_div (
  input  logic              clk,
  input  logic              rst_n,
  input  rau_pkg::div_req_t req,
  output rau_pkg::div_rsp_t rsp
);

  logic                              busy_r;
  logic                              done_r;
  logic [rau_pkg::CNT_W-1:0]         cnt_r;
  logic [rau_pkg::WIDTH-1:0]         rem_r;
  logic [rau_pkg::WIDTH-1:0]         quo_r;
  logic [rau_pkg::WIDTH-1:0]         den_r;

  logic [rau_pkg::WIDTH:0]           trial;
  logic                              ge;
  logic [rau_pkg::WIDTH:0]           diff;

  assign trial = {rem_r, quo_r[rau_pkg::WIDTH-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= req.dividend;
        den_r  <= req.divisor;
      end else if (busy_r) begin
        // partial remainder stays below the divisor, so it fits WIDTH bits
        rem_r <= ge ? diff[rau_pkg::WIDTH-1:0] : trial[rau_pkg::WIDTH-1:0];
        quo_r <= {quo_r[rau_pkg::WIDTH-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == rau_pkg::CNT_W'(rau_pkg::WIDTH - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy      = busy_r;
  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

endmodule

// File: rtl/rational_arith_unit.sv
// Sequence: add, subtract, multiply, divide take three multiplier passes, a combine
//   step and the output register. Reduce goes straight to the output when the gcd
//   is zero, else runs Euclid remainder steps on the divider, then two quotients.
// Flow: the sequencer works on one transaction at a time; the next is taken the cycle
//   after the result is registered; the bit-serial divider paces reduce.
// Reset: synchronous active-low rst_n returns to idle and drops out_valid.
module rational_arith_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  rau_pkg::rau_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rau_pkg::rau_out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE,  // waiting for a transaction
    S_MUL,   // three passes through the shared multiplier
    S_SUM,   // combine cross products
    S_GCD,   // Euclid loop head: test x, launch a remainder or the first quotient
    S_REM,   // wait for remainder y % x
    S_QN,    // wait for a_num / g
    S_QD,    // wait for a_den / g
    S_OUT    // hand result to the output register
  } state_t;

  state_t                      state_r;
  logic [2:0]                  op_r;
  logic [rau_pkg::WIDTH-1:0]   an_r, ad_r, bn_r, bd_r;
  logic [1:0]                  mcnt_r;
  logic [rau_pkg::WIDTH-1:0]   p0_r, p1_r, p2_r;
  // Euclid pair: loop runs while x != 0, gcd ends in y
  logic [rau_pkg::WIDTH-1:0]   x_r, y_r;
  logic [rau_pkg::WIDTH-1:0]   rn_r, rd_r;
  logic                        out_valid_r;
  rau_pkg::rau_out_t           out_data_r;

  logic [rau_pkg::WIDTH-1:0]   mul_a, mul_b, prod;
  rau_pkg::div_req_t           div_req;
  rau_pkg::div_rsp_t           div_rsp;
  logic [rau_pkg::WIDTH-1:0]   dsrc, vsrc;
  logic [rau_pkg::WIDTH-1:0]   rem_s, quo_n, quo_d;
  logic                        out_load;

  function automatic logic [rau_pkg::WIDTH-1:0] mag(input logic [rau_pkg::WIDTH-1:0] v);
    mag = v[rau_pkg::WIDTH-1] ? (~v + 1'b1) : v;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // result moves into the output register when it is empty or draining
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // ---------------------------------------------------------------------------
  // Shared multiplier. Only the low WIDTH bits of each product are kept, which
  // is the same for signed and unsigned operands.
  //   pass 0: an*bd (an*bn for multiply)
  //   pass 1: bn*ad (used by add / subtract only)
  //   pass 2: ad*bd (ad*bn for divide)
  // ---------------------------------------------------------------------------
  always_comb begin
    unique case (mcnt_r)
      2'd0: begin
        mul_a = an_r;
        mul_b = (op_r == rau_pkg::OP_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        mul_a = bn_r;
        mul_b = ad_r;
      end
      default: begin
        mul_a = ad_r;
        mul_b = (op_r == rau_pkg::OP_DIV) ? bn_r : bd_r;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // Divider requests. The divider works on magnitudes; signs are restored
  // here: a truncated remainder takes the dividend's sign, a truncated
  // quotient is negated when the operand signs differ. A most negative
  // dividend over minus one comes back as the same value through the wrap.
  // ---------------------------------------------------------------------------
  always_comb begin
    div_req.start = 1'b0;
    dsrc          = y_r;
    vsrc          = x_r;
    unique case (state_r)
      S_GCD: begin
        if (x_r == '0) begin
          // loop finished: g = y; divide only when g is nonzero
          dsrc          = an_r;
          vsrc          = y_r;
          div_req.start = (y_r != '0);
        end else begin
          div_req.start = 1'b1;
        end
      end
      S_QN: begin
        dsrc          = ad_r;
        vsrc          = y_r;
        div_req.start = div_rsp.done;
      end
      default: begin
      end
    endcase
    div_req.dividend = mag(dsrc);
    div_req.divisor  = mag(vsrc);
  end

  assign rem_s = y_r[rau_pkg::WIDTH-1] ? (~div_rsp.remainder + 1'b1) : div_rsp.remainder;
  assign quo_n = (an_r[rau_pkg::WIDTH-1] ^ y_r[rau_pkg::WIDTH-1]) ? (~div_rsp.quotient + 1'b1)
                                                                  : div_rsp.quotient;
  assign quo_d = (ad_r[rau_pkg::WIDTH-1] ^ y_r[rau_pkg::WIDTH-1]) ? (~div_rsp.quotient + 1'b1)
                                                                  : div_rsp.quotient;

  rau_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // Sequencer and output register. The output register frees the sequencer:
  // a new transaction may be taken while the previous result is still
  // stalled, and S_OUT holds the next result until the register empties.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mcnt_r      <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r   <= in_data.op;
            an_r   <= in_data.a_num;
            ad_r   <= in_data.a_den;
            bn_r   <= in_data.b_num;
            bd_r   <= in_data.b_den;
            x_r    <= in_data.a_num;
            y_r    <= in_data.a_den;
            rn_r   <= in_data.a_num;
            rd_r   <= in_data.a_den;
            mcnt_r <= '0;
            if (in_data.op == rau_pkg::OP_RED) begin
              state_r <= S_GCD;
            end else if (in_data.op > rau_pkg::OP_RED) begin
              // unused codes pass the first fraction through
              state_r <= S_OUT;
            end else begin
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          unique case (mcnt_r)
            2'd0:    p0_r <= prod;
            2'd1:    p1_r <= prod;
            default: p2_r <= prod;
          endcase
          mcnt_r <= mcnt_r + 1'b1;
          if (mcnt_r == 2'd2) begin
            state_r <= S_SUM;
          end
        end
        S_SUM: begin
          unique case (op_r)
            rau_pkg::OP_ADD: rn_r <= p0_r + p1_r;
            rau_pkg::OP_SUB: rn_r <= p0_r - p1_r;
            default:         rn_r <= p0_r;
          endcase
          rd_r    <= p2_r;
          state_r <= S_OUT;
        end
        S_GCD: begin
          if (x_r != '0) begin
            state_r <= S_REM;
          end else if (y_r != '0) begin
            state_r <= S_QN;
          end else begin
            // gcd zero: result stays a_num / a_den
            state_r <= S_OUT;
          end
        end
        S_REM: begin
          if (div_rsp.done) begin
            y_r     <= x_r;
            x_r     <= rem_s;
            state_r <= S_GCD;
          end
        end
        S_QN: begin
          if (div_rsp.done) begin
            rn_r    <= quo_n;
            state_r <= S_QD;
          end
        end
        S_QD: begin
          if (div_rsp.done) begin
            rd_r    <= quo_d;
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_data_r.res_num <= rn_r;
            out_data_r.res_den <= rd_r;
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  // divider is never relaunched mid-division
  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // divisor is never zero at launch
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> (div_req.divisor != '0))
    else $error("divider started with zero divisor");

  // divider results arrive only where the sequencer waits for them
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == S_REM || state_r == S_QN || state_r == S_QD))
    else $error("divider result outside a wait state");

  // an accepted transaction always leaves idle
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("transaction accepted but sequencer idle");
`endif

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rau_pkg::*;

  // op codes 5..7 are not decoded; the first fraction passes through
  localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [2:0] OP_SPARE_LAST  = 3'd7;

  localparam logic signed [WIDTH-1:0] FRAC_MIN = {1'b1, {(WIDTH-1){1'b0}}};
  localparam logic signed [WIDTH-1:0] FRAC_MAX = ~FRAC_MIN;

  // consecutive Fibonacci numbers: the longest Euclid chain in 32 bits
  localparam logic signed [WIDTH-1:0] FIB_45 = 32'sd1134903170;
  localparam logic signed [WIDTH-1:0] FIB_46 = 32'sd1836311903;

  localparam int HOLD_CYCLES  = 400;  // long receiver hold-off
  localparam int DRAIN_CYCLES = 50;   // quiet time after the last result
  localparam int MAX_REPORTS  = 10;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  rau_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  rau_out_t out_data;

  // expected result fractions, oldest first
  rau_out_t pending_fracs[$];
  int       mismatch_cnt;

  // shared knobs between the test sequence and the receiver
  bit       idle_on;     // random gaps and stalls enabled
  event     hold_go;     // ask the hold-off process for a long stall
  logic     hold_off;    // driven by the hold-off process only

  rational_arith_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ------------------------------------------------------------------
  // Result prediction. Everything wraps at WIDTH bits; the gcd runs in
  // 64-bit signed math so that truncated % and / never overflow, and
  // MIN / -1 comes back as MIN once truncated to WIDTH bits.
  // ------------------------------------------------------------------
  function automatic rau_out_t fraction_result(rau_in_t item);
    rau_out_t res;
    longint   an;
    longint   ad;
    longint   x;
    longint   y;
    longint   rem;
    res.res_num = item.a_num;
    res.res_den = item.a_den;
    an = longint'(item.a_num);
    ad = longint'(item.a_den);
    case (item.op)
      OP_ADD: begin
        res.res_num = item.a_num * item.b_den + item.b_num * item.a_den;
        res.res_den = item.a_den * item.b_den;
      end
      OP_SUB: begin
        res.res_num = item.a_num * item.b_den - item.b_num * item.a_den;
        res.res_den = item.a_den * item.b_den;
      end
      OP_MUL: begin
        res.res_num = item.a_num * item.b_num;
        res.res_den = item.a_den * item.b_den;
      end
      OP_DIV: begin
        // multiply by the reciprocal of the second fraction
        res.res_num = item.a_num * item.b_den;
        res.res_den = item.a_den * item.b_num;
      end
      OP_RED: begin
        // Euclid with truncated remainders; the gcd may come out negative
        x = an;
        y = ad;
        for (int i = 0; i < 200 && x != 0; i++) begin
          rem = y % x;
          y = x;
          x = rem;
        end
        if (y != 0) begin
          res.res_num = WIDTH'(an / y);
          res.res_den = WIDTH'(ad / y);
        end
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic rau_in_t make_item(logic [2:0] op,
                                        logic signed [WIDTH-1:0] an,
                                        logic signed [WIDTH-1:0] ad,
                                        logic signed [WIDTH-1:0] bn,
                                        logic signed [WIDTH-1:0] bd);
    rau_in_t item;
    item.op    = op;
    item.a_num = an;
    item.a_den = ad;
    item.b_num = bn;
    item.b_den = bd;
    return item;
  endfunction

  // operand mix: extremes, zero, minus one, small values, full range
  function automatic logic signed [WIDTH-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0:       return FRAC_MIN;
      1:       return FRAC_MAX;
      2:       return '0;
      3:       return '1;
      4, 5:    return int'($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic rau_in_t rand_item();
    rau_in_t item;
    int      pick;
    int      factor;
    pick       = $urandom_range(0, 99);
    item.a_num = rand_operand();
    item.a_den = rand_operand();
    item.b_num = rand_operand();
    item.b_den = rand_operand();
    if (pick < 70) begin
      item.op = 3'($urandom_range(OP_ADD, OP_DIV));
    end else if (pick < 90) begin
      item.op = OP_RED;
      // half of the reductions get a shared factor so the gcd is not trivial
      if ($urandom_range(0, 1)) begin
        factor     = int'($urandom_range(1, 5000));
        item.a_num = factor * (int'($urandom_range(0, 40000)) - 20000);
        item.a_den = factor * (int'($urandom_range(0, 40000)) - 20000);
      end
    end else begin
      item.op = 3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
    end
    return item;
  endfunction

  // ------------------------------------------------------------------
  // Sender. Entered and left on a rising-edge time step. in_valid stays
  // high across back-to-back transactions; it is only lowered for a gap.
  // ------------------------------------------------------------------
  task automatic send_item(rau_in_t item);
    int gap;
    gap = idle_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (in_stall);
    pending_fracs.push_back(fraction_result(item));
  endtask

  // ------------------------------------------------------------------
  // Receiver and checker. Samples on the rising edge (pre-edge values),
  // then draws a stall stretch for the next result.
  // ------------------------------------------------------------------
  initial begin : result_check
    rau_out_t want;
    int       stall_left;
    stall_left = 0;
    out_stall  = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (pending_fracs.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORTS)
            $display("unexpected result: num=%0d den=%0d",
                     out_data.res_num, out_data.res_den);
        end else begin
          want = pending_fracs.pop_front();
          if (out_data.res_num !== want.res_num) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("res_num mismatch: expected %0d, got %0d",
                       want.res_num, out_data.res_num);
          end
          if (out_data.res_den !== want.res_den) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MAX_REPORTS)
              $display("res_den mismatch: expected %0d, got %0d",
                       want.res_den, out_data.res_den);
          end
        end
        stall_left = idle_on ? $urandom_range(0, 5) : 0;
      end
      out_stall <= hold_off || (stall_left != 0);
      if (stall_left != 0)
        stall_left--;
    end
  end

  // long hold-off on the result side, counted here in cycles
  initial begin : hold_off_ctrl
    hold_off = 1'b0;
    forever begin
      @(hold_go);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_off <= 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------

  // the four two-fraction ops at the field extremes, plus small values
  // and zero denominators, which are passed through and checked like the rest
  task automatic test_arith_extremes();
    logic [2:0] arith_ops [4] = '{OP_ADD, OP_SUB, OP_MUL, OP_DIV};
    foreach (arith_ops[i]) begin
      send_item(make_item(arith_ops[i], FRAC_MAX, FRAC_MIN, FRAC_MIN, FRAC_MAX));
      send_item(make_item(arith_ops[i], 3, 4, -5, 7));
    end
    send_item(make_item(OP_ADD, 1, 0, 1, 0));
    send_item(make_item(OP_DIV, FRAC_MIN, '1, '0, FRAC_MIN));
  endtask

  task automatic test_reduce_cases();
    // zero numerator: gcd is the denominator, giving 0/1
    send_item(make_item(OP_RED, 0, 5, 0, 0));
    // zero over zero: gcd zero, nothing divided
    send_item(make_item(OP_RED, 0, 0, 0, 0));
    // negative gcd flips both signs
    send_item(make_item(OP_RED, 4, -6, 0, 0));
    // most negative over minus one wraps back to itself
    send_item(make_item(OP_RED, FRAC_MIN, '1, 0, 0));
    send_item(make_item(OP_RED, FRAC_MIN, FRAC_MIN, 0, 0));
    send_item(make_item(OP_RED, 7, 0, 0, 0));
    // longest Euclid chain
    send_item(make_item(OP_RED, FIB_45, FIB_46, 0, 0));
    // second fraction must have no effect
    send_item(make_item(OP_RED, 12, 18, FRAC_MAX, FRAC_MIN));
    send_item(make_item(OP_RED, 12, 18, $urandom, $urandom));
  endtask

  task automatic test_unused_ops();
    for (int c = OP_SPARE_FIRST; c <= OP_SPARE_LAST; c++)
      send_item(make_item(3'(c), FRAC_MIN, FRAC_MAX, $urandom, $urandom));
  endtask

  task automatic test_random_traffic(int count, bit with_idle);
    idle_on = with_idle;
    repeat (count) send_item(rand_item());
  endtask

  // receiver holds off for a long stretch while the sender keeps
  // offering back to back; the block fills up and stalls its input
  task automatic test_output_backpressure();
    idle_on = 1'b0;
    -> hold_go;
    repeat (40) send_item(rand_item());
    idle_on = 1'b1;
  endtask

  // ------------------------------------------------------------------
  // Sequence
  // ------------------------------------------------------------------
  initial begin : main_seq
    mismatch_cnt = 0;
    idle_on      = 1'b1;
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_data      = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_arith_extremes();
    test_reduce_cases();
    test_unused_ops();
    test_random_traffic(1000, 1'b1);
    test_random_traffic(450, 1'b0);
    test_output_backpressure();
    test_random_traffic(450, 1'b1);

    in_valid <= 1'b0;
    while (pending_fracs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_cnt == 0 && pending_fracs.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // timeout, sized for every transaction being a worst-case reduce
  initial begin : watchdog
    #200_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
